### rtl/sfla_pkg.sv
`default_nettype none

package sfla_pkg;

    // Pool size, 1 to 128 slots
    localparam int NUM_SLOTS = 16;

    // Fixed field widths
    localparam int CMD_W   = 2;
    localparam int SLOT_W  = 8;
    localparam int GRANT_W = 7;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 8;

    // Pointer and bitmap index width
    localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FREE  = 2'd3;

    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(NUM_SLOTS);

    // Queue control from the decision logic
    typedef struct packed {
        logic               pop;
        logic               push;
        logic [GRANT_W-1:0] push_slot;
    } t_q_ctrl;

endpackage

`default_nettype wire

### rtl/sfla_queue.sv
`default_nettype none

module sfla_queue (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire  sfla_pkg::t_q_ctrl         i_ctrl,
    output logic [sfla_pkg::GRANT_W-1:0]    o_head_slot,
    output logic [sfla_pkg::CNT_W-1:0]      o_count
);
    import sfla_pkg::*;

    logic [GRANT_W-1:0] r_q [NUM_SLOTS];
    logic [IDX_W-1:0]   r_head;
    logic [IDX_W-1:0]   r_tail;
    logic [CNT_W-1:0]   r_count;

    function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p);
        wrap_next = (p == IDX_W'(NUM_SLOTS - 1)) ? '0 : p + 1'b1;
    endfunction

    assign o_head_slot = r_q[r_head];
    assign o_count     = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_q[i] <= GRANT_W'(i);
            end
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= FULL_COUNT;
        end else begin
            if (i_ctrl.push) begin
                r_q[r_tail] <= i_ctrl.push_slot;
                r_tail      <= wrap_next(r_tail);
            end
            if (i_ctrl.pop) begin
                r_head <= wrap_next(r_head);
            end
            case ({i_ctrl.push, i_ctrl.pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

`default_nettype wire

### rtl/slot_free_list_allocator.sv
`default_nettype none

// Slot allocator: hands out slot numbers 0 to NUM_SLOTS-1 from a FIFO of free
// slots (oldest freed slot first) and tracks occupied slots in a bitmap.
// Issue a command by raising start with i_cmd and i_slot; busy is always low,
// so one command may be issued every cycle. Each command yields exactly one
// result, shown on the o_ ports for one cycle with o_strobe high, after the
// command has passed the input register and then the head-entry read, bitmap
// bit and count update into the result register. The receiver cannot stall
// and must take each result as it comes.
// Command 0 allocates, 1 releases the named slot, 2 and 3 only query.
// Every result carries the free count and the free state of i_slot after the
// command took effect.
module slot_free_list_allocator (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             start,
    output logic                            busy,
    input  wire  [sfla_pkg::CMD_W-1:0]      i_cmd,
    input  wire  [sfla_pkg::SLOT_W-1:0]     i_slot,
    output logic                            o_strobe,
    output logic [sfla_pkg::GRANT_W-1:0]    o_granted_slot,
    output logic [sfla_pkg::STAT_W-1:0]     o_status,
    output logic                            o_slot_is_free,
    output logic [sfla_pkg::CNT_W-1:0]      o_free_count
);
    import sfla_pkg::*;

    // Input register
    logic              r_in_vld;
    logic [CMD_W-1:0]  r_cmd;
    logic [SLOT_W-1:0] r_slot;

    // Occupied bitmap
    logic [NUM_SLOTS-1:0] r_occ;
    logic [NUM_SLOTS-1:0] n_occ;

    // Queue interface
    t_q_ctrl            q_ctrl;
    logic [GRANT_W-1:0] q_head_slot;
    logic [CNT_W-1:0]   q_count;

    // Result next values
    logic [GRANT_W-1:0] n_granted;
    logic [STAT_W-1:0]  n_status;
    logic               n_is_free;
    logic [CNT_W-1:0]   n_count;

    logic             in_range;
    logic [IDX_W-1:0] slot_idx;
    logic [IDX_W-1:0] head_idx;

    // The block never holds off a command
    assign busy = 1'b0;

    sfla_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (q_ctrl),
        .o_head_slot (q_head_slot),
        .o_count     (q_count)
    );

    // Capture the command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= start && !busy;
        end
        if (start && !busy) begin
            r_cmd  <= i_cmd;
            r_slot <= i_slot;
        end
    end

    assign in_range = (r_slot < SLOT_W'(NUM_SLOTS));
    assign slot_idx = r_slot[IDX_W-1:0];
    assign head_idx = q_head_slot[IDX_W-1:0];

    // Decide the action for the registered command in one pass
    always_comb begin
        q_ctrl           = '0;
        q_ctrl.push_slot = r_slot[GRANT_W-1:0];
        n_occ            = r_occ;
        n_granted        = '0;
        n_status         = ST_OK;
        if (r_in_vld) begin
            case (r_cmd)
                CMD_ALLOC: begin
                    if (q_count == '0) begin
                        n_status = ST_EMPTY;
                    end else begin
                        // pop the oldest free slot and mark it taken
                        q_ctrl.pop = 1'b1;
                        if ({1'b0, q_head_slot} < (GRANT_W + 1)'(NUM_SLOTS)) begin
                            n_occ[head_idx] = 1'b1;
                        end
                        n_granted = q_head_slot;
                    end
                end
                CMD_RELEASE: begin
                    if (!in_range) begin
                        n_status = ST_RANGE;
                    end else if (!r_occ[slot_idx]) begin
                        n_status = ST_FREE;
                    end else if (q_count < FULL_COUNT) begin
                        n_occ[slot_idx] = 1'b0;
                        q_ctrl.push     = 1'b1;
                    end
                end
                default: begin
                    // query and the unused code change nothing
                    if (!in_range) begin
                        n_status = ST_RANGE;
                    end
                end
            endcase
        end
        n_is_free = in_range && !n_occ[slot_idx];
        n_count   = q_count + CNT_W'(q_ctrl.push) - CNT_W'(q_ctrl.pop);
    end

    // Advance the bitmap and drive the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= '0;
            o_strobe <= 1'b0;
        end else begin
            r_occ    <= n_occ;
            o_strobe <= r_in_vld;
        end
        o_granted_slot <= n_granted;
        o_status       <= n_status;
        o_slot_is_free <= n_is_free;
        o_free_count   <= n_count;
    end

    // Free count and occupied bitmap always account for every slot
    a_conserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(q_count) + 32'($countones(r_occ))) == NUM_SLOTS)
        else $error("free count and occupied bitmap disagree");

    // Every command taken yields a result strobe through the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_strobe)
        else $error("result strobe missing for a taken command");

    // An empty report means the pool really was empty
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_EMPTY) |-> (o_free_count == '0))
        else $error("empty status with free slots left");

    // A nonzero grant only comes with an ok status
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_granted_slot != '0) |-> (o_status == ST_OK))
        else $error("slot granted on a failed command");

endmodule

`default_nettype wire
